[hdl/trfd_pkg.sv]
// Shared types, constants and helper functions for the touch report frame decoder.
// Used by trfd_front, trfd_back and touch_report_frame_decoder; no dependencies.
package trfd_pkg;

    // Default number of touch slots and the fixed length of one report frame.
    localparam int MAX_SLOTS_DEF   = 2;
    localparam int FRAME_BYTES     = 15;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Frame layout: the point count sits at offset 2, and the points start at offset 3.
    localparam logic [3:0] POS_COUNT      = 4'd2;
    localparam logic [3:0] POINT_BASE     = 4'd3;
    localparam logic [3:0] POINT_STRIDE   = 4'd6;
    localparam logic [3:0] POS_LAST       = 4'(FRAME_BYTES - 1);
    localparam logic [3:0] COUNT_MASK     = 4'hF;

    // Byte offsets within one point record.
    localparam logic [2:0] OFF_EVENT_XHI = 3'd0;
    localparam logic [2:0] OFF_XLO       = 3'd1;
    localparam logic [2:0] OFF_ID_YHI    = 3'd2;
    localparam logic [2:0] OFF_YLO       = 3'd3;

    // Item kinds.
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IRQ_ACTIVE_LOW = 1'b0;
    localparam logic CFG_HAS_IRQ_PIN    = 1'b1;

    // Event codes in bits 7:6 of the first point byte.
    localparam logic [1:0] EVT_DOWN    = 2'd0;
    localparam logic [1:0] EVT_UP      = 2'd1;
    localparam logic [1:0] EVT_CONTACT = 2'd2;

    // Reported touch states.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DOWN    = 2'd1;
    localparam logic [1:0] ST_UP      = 2'd2;
    localparam logic [1:0] ST_CONTACT = 2'd3;

    localparam logic [1:0] TALLY_MAX = 2'd3;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [1:0]  st;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    function automatic logic [1:0] code_to_state(input logic [1:0] code);
        logic [1:0] st;
        begin
            case (code)
                EVT_DOWN:    st = ST_DOWN;
                EVT_UP:      st = ST_UP;
                EVT_CONTACT: st = ST_CONTACT;
                default:     st = ST_NONE;
            endcase
            return st;
        end
    endfunction

endpackage

[hdl/trfd_front.sv]
// Front end of the touch report frame decoder: accepts polls and frame bytes,
// keeps the frame and slot state and queues one work entry per result burst. Uses trfd_pkg.
module trfd_front #(
    parameter int MAX_SLOTS = trfd_pkg::MAX_SLOTS_DEF,
    parameter int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int ENTRY_W   = 3 + MAX_SLOTS * trfd_pkg::SLOT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         frame_byte,
    input  logic               irq_level,
    input  logic               q_full,
    output logic               push,
    output logic [ENTRY_W-1:0] push_entry
);

    trfd_pkg::slot_t [MAX_SLOTS-1:0] slots_reg, slots_next;
    logic [3:0] pos_reg, pos_next;
    logic [1:0] npts_reg, npts_next;
    logic [7:0] held1_reg, held1_next;
    logic [7:0] held2_reg, held2_next;
    logic [1:0] tally_reg, tally_next;
    logic       had_reg, had_next;
    logic       irq_low_reg, has_pin_reg;

    logic              accept;
    logic              line_active;
    logic              read_req;
    logic [3:0]        rel;
    logic              idx;
    logic [3:0]        off_wide;
    logic [2:0]        off;
    logic [3:0]        id;
    logic [SLOT_W-1:0] sel;
    logic [1:0]        new_st;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        slots_next = slots_reg;
        pos_next   = pos_reg;
        npts_next  = npts_reg;
        held1_next = held1_reg;
        held2_next = held2_reg;
        tally_next = tally_reg;
        had_next   = had_reg;
        push       = 1'b0;
        read_req   = 1'b0;
        line_active = has_pin_reg && (irq_low_reg ? !irq_level : irq_level);
        rel        = pos_reg - trfd_pkg::POINT_BASE;
        idx        = (rel >= trfd_pkg::POINT_STRIDE);
        off_wide   = idx ? (rel - trfd_pkg::POINT_STRIDE) : rel;
        off        = off_wide[2:0];
        id         = '0;
        sel        = '0;
        new_st     = trfd_pkg::code_to_state(held1_reg[7:6]);
        if (accept)
        begin
            if (func == trfd_pkg::FUNC_POLL)
            begin
                pos_next = '0;
                push     = 1'b1;
                if (has_pin_reg && !line_active && !had_reg)
                begin
                    slots_next = '0;
                    tally_next = '0;
                end
                else
                begin
                    read_req = 1'b1;
                end
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    slots_next = '0;
                    tally_next = '0;
                    npts_next  = '0;
                end
                else if (pos_reg == trfd_pkg::POS_COUNT)
                begin
                    if ((frame_byte[3:0] & trfd_pkg::COUNT_MASK) > 4'(MAX_SLOTS))
                        npts_next = 2'(MAX_SLOTS);
                    else
                        npts_next = frame_byte[1:0];
                end
                else if (pos_reg >= trfd_pkg::POINT_BASE && {1'b0, idx} < npts_reg)
                begin
                    case (off)
                        trfd_pkg::OFF_EVENT_XHI:
                        begin
                            held1_next = frame_byte;
                        end
                        trfd_pkg::OFF_XLO:
                        begin
                            held2_next = frame_byte;
                        end
                        trfd_pkg::OFF_ID_YHI:
                        begin
                            id = frame_byte[7:4];
                            sel = (id < 4'(MAX_SLOTS)) ? id[SLOT_W-1:0] : SLOT_W'(idx);
                            slots_next[sel].x  = {held1_reg[3:0], held2_reg};
                            slots_next[sel].st = new_st;
                            if ((new_st == trfd_pkg::ST_DOWN || new_st == trfd_pkg::ST_CONTACT)
                                && tally_reg < trfd_pkg::TALLY_MAX)
                                tally_next = tally_reg + 2'd1;
                            held2_next = frame_byte;
                        end
                        trfd_pkg::OFF_YLO:
                        begin
                            id = held2_reg[7:4];
                            sel = (id < 4'(MAX_SLOTS)) ? id[SLOT_W-1:0] : SLOT_W'(idx);
                            slots_next[sel].y = {held2_reg[3:0], frame_byte};
                        end
                        default:
                        begin
                            id = '0;
                        end
                    endcase
                end
                if (pos_reg >= trfd_pkg::POS_LAST)
                begin
                    pos_next = '0;
                    had_next = (tally_next != '0);
                    push     = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    assign push_entry = {read_req, tally_next, slots_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg   <= '0;
            pos_reg     <= '0;
            npts_reg    <= '0;
            held1_reg   <= '0;
            held2_reg   <= '0;
            tally_reg   <= '0;
            had_reg     <= 1'b0;
            irq_low_reg <= 1'b1;
            has_pin_reg <= 1'b1;
        end
        else
        begin
            slots_reg <= slots_next;
            pos_reg   <= pos_next;
            npts_reg  <= npts_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
            tally_reg <= tally_next;
            had_reg   <= had_next;
            if (cfg_we && cfg_index == trfd_pkg::CFG_IRQ_ACTIVE_LOW)
                irq_low_reg <= cfg_data;
            if (cfg_we && cfg_index == trfd_pkg::CFG_HAS_IRQ_PIN)
                has_pin_reg <= cfg_data;
        end
    end

`ifndef NO_ASSERTIONS
    // The frame offset wraps after the last byte and never runs past it.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= trfd_pkg::POS_LAST)
        else $error("frame offset out of range");

    // The final frame byte always queues a slot burst.
    a_last_byte_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == trfd_pkg::FUNC_BYTE && pos_reg == trfd_pkg::POS_LAST)
        |-> (push && !read_req))
        else $error("final frame byte did not queue slot results");
`endif

endmodule

[hdl/trfd_queue.sv]
// Short first-in first-out queue between the front and back ends of the decoder.
// Generic over entry width and depth; no package dependencies.
module trfd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2,
    parameter int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data,
    input  logic              pop
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The front end only pushes when the queue has room, so no entry is dropped.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    // The fill count stays within the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

[hdl/trfd_back.sv]
// Back end of the touch report frame decoder: expands each queued entry into
// one read request or one result per slot, through a registered output stage. Uses trfd_pkg.
module trfd_back #(
    parameter int MAX_SLOTS = trfd_pkg::MAX_SLOTS_DEF,
    parameter int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int ENTRY_W   = 3 + MAX_SLOTS * trfd_pkg::SLOT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  logic [ENTRY_W-1:0] head_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               slot_index,
    output logic [11:0]        x_pos,
    output logic [11:0]        y_pos,
    output logic [1:0]         touch_state,
    output logic [1:0]         active_count,
    output logic               read_request,
    output logic               last_result
);

    trfd_pkg::slot_t [MAX_SLOTS-1:0] head_slots;
    trfd_pkg::slot_t                 cur;
    logic                            head_rr;
    logic [1:0]                      head_tally;
    logic                            load;
    logic                            last;

    logic [SLOT_W-1:0] k_reg, k_next;
    logic              valid_reg, valid_next;
    logic              slot_reg;
    logic [11:0]       x_reg;
    logic [11:0]       y_reg;
    logic [1:0]        st_reg;
    logic [1:0]        count_reg;
    logic              rr_reg;
    logic              last_reg;

    assign head_slots = head_entry[MAX_SLOTS*trfd_pkg::SLOT_BITS-1:0];
    assign head_tally = head_entry[ENTRY_W-2 -: 2];
    assign head_rr    = head_entry[ENTRY_W-1];
    assign cur        = head_slots[k_reg];

    assign load = head_valid && (!valid_reg || !out_stall);
    assign last = head_rr || (k_reg == SLOT_W'(MAX_SLOTS - 1));
    assign pop  = load && last;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            k_next     = last ? '0 : k_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg  <= head_rr ? 1'b0 : k_reg[0];
            x_reg     <= head_rr ? '0 : cur.x;
            y_reg     <= head_rr ? '0 : cur.y;
            st_reg    <= head_rr ? trfd_pkg::ST_NONE : cur.st;
            count_reg <= head_rr ? '0 : head_tally;
            rr_reg    <= head_rr;
            last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign slot_index   = slot_reg;
    assign x_pos        = x_reg;
    assign y_pos        = y_reg;
    assign touch_state  = st_reg;
    assign active_count = count_reg;
    assign read_request = rr_reg;
    assign last_result  = last_reg;

`ifndef NO_ASSERTIONS
    // While an entry is partly expanded it must still sit at the queue head.
    a_mid_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != '0) |-> head_valid)
        else $error("queue head vanished during expansion");

    // A read request is a single, empty result.
    a_read_req_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && rr_reg) |-> (last_reg && x_reg == '0 && y_reg == '0 && count_reg == '0))
        else $error("malformed read request result");
`endif

endmodule

[hdl/touch_report_frame_decoder.sv]
// Top level of the touch report frame decoder: front end, work queue and back end.
// Depends on trfd_pkg, trfd_front, trfd_queue and trfd_back.

// The decoder takes one item per clock on the input channel: either a poll, which
// samples the interrupt line level under the configured polarity, or one byte of a
// 15-byte touch report frame. Every frame byte and every poll is handled in the
// cycle it is accepted, so an input item may follow in the very next cycle. A poll
// produces either one read request result or, when a pin is wired, the line is
// inactive and the last frame had no active touch, one cleared result per slot. The
// final frame byte produces one result per slot carrying the decoded coordinates,
// states and active point count; all other bytes produce no result. Results leave
// one per clock, unless the output stalls, through a registered output stage;
// an item yields MAX_SLOTS results for a slot burst and one for a read request.
// A queue of QUEUE_DEPTH entries sits between the front and back ends; input stalls
// only while that queue is full, so a stalled output also blocks frame bytes that
// produce no result once that queue has filled. Configuration writes (index 0:
// interrupt active low, index 1: interrupt pin present) take effect at the next clock
// and are meant to be made while the decoder is idle.
module touch_report_frame_decoder #(
    parameter int MAX_SLOTS   = trfd_pkg::MAX_SLOTS_DEF,
    parameter int QUEUE_DEPTH = trfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  frame_byte,
    input  logic        irq_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        slot_index,
    output logic [11:0] x_pos,
    output logic [11:0] y_pos,
    output logic [1:0]  touch_state,
    output logic [1:0]  active_count,
    output logic        read_request,
    output logic        last_result
);

    // Slot index width and queue entry width: a read request flag, the active
    // tally and a snapshot of every slot.
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ENTRY_W = 3 + MAX_SLOTS * trfd_pkg::SLOT_BITS;

    logic               q_full;
    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               head_valid;
    logic [ENTRY_W-1:0] head_entry;
    logic               pop;

    // The front end owns all decoder state and decides, per item, whether a
    // burst of results is due; if so it queues a snapshot of the slots.
    trfd_front #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .frame_byte (frame_byte),
        .irq_level  (irq_level),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue lets the front end keep taking items while results wait.
    trfd_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_entry),
        .pop        (pop)
    );

    // The back end walks each entry one result per cycle while the output is not
    // stalled, and pops it with the last result.
    trfd_back #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_index   (slot_index),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .touch_state  (touch_state),
        .active_count (active_count),
        .read_request (read_request),
        .last_result  (last_result)
    );

endmodule
